[hw/rtl/brsa_pkg.sv]
// Package for the slot allocator: shared widths, command and register codes,
// and the structs passed between the configuration, map and sequencer blocks.
// No dependencies.
`default_nettype none

package brsa_pkg;

  localparam int unsigned Slots    = 256;
  localparam int unsigned IdxW     = $clog2(Slots);
  localparam int unsigned CntW     = 9;
  localparam int unsigned AddrW    = 48;
  localparam int unsigned StrideW  = 13;
  localparam int unsigned OffW     = IdxW + StrideW;
  localparam int unsigned DataW    = 64;
  localparam int unsigned PaddrW   = 5;

  localparam logic [IdxW-1:0] LastIdx    = IdxW'(Slots - 1);
  localparam logic [CntW-1:0] SlotsCnt   = CntW'(Slots);
  localparam logic [StrideW-1:0] StrideRst = StrideW'(32);
  localparam logic [CntW-1:0] ActiveRst  = CntW'(256);

  typedef enum logic {
    CmdAlloc = 1'b0,
    CmdFree  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    RegCpuBase = 2'd0,
    RegGpuBase = 2'd1,
    RegStride  = 2'd2,
    RegActive  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [AddrW-1:0]   cpu_base;
    logic [AddrW-1:0]   gpu_base;
    logic [StrideW-1:0] stride;
    logic [CntW-1:0]    active;
  } cfg_t;

  typedef struct packed {
    logic shift;
    logic wr_bit;
  } map_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/bitmap_range_slot_allocator.sv]
// Bitmap range slot allocator: first-fit contiguous slot allocation and
// release. Top level; depends on brsa_pkg, brsa_cfg, brsa_map, brsa_seq.
//
// Input channel (in_valid_i/in_stall_o) carries one command per transfer:
// allocate count slots, or free count slots from start_index. Output
// channel (out_valid_o/out_stall_i) returns one result per command.
// The used map is a rotating shift register that presents one slot per
// cycle, so each pass over it visits all Slots (256) slots.
// A free takes one clearing pass; an allocate takes one scan pass and, when
// a run is found, one marking pass. The result is registered in the finish
// state after the last pass, once the output register is free. One command
// is in work at a time; in_stall_o is high from acceptance until the result
// is placed in the output register. A held result does not block the next
// command; a command that finishes while the previous result is still
// stalled waits until that transfer. Reset clears the map (every slot free)
// and loads the register defaults. The user writes registers over the
// APB-style port only while no command is active; the block does not enforce it.
`default_nettype none

module bitmap_range_slot_allocator (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [brsa_pkg::PaddrW-1:0] paddr,
  input  wire logic [brsa_pkg::DataW-1:0]  pwdata,
  output logic      [brsa_pkg::DataW-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        command_i,
  input  wire logic [brsa_pkg::CntW-1:0]   count_i,
  input  wire logic [brsa_pkg::IdxW-1:0]   start_index_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             ok_o,
  output logic      [brsa_pkg::IdxW-1:0]   first_slot_o,
  output logic      [brsa_pkg::AddrW-1:0]  cpu_address_o,
  output logic      [brsa_pkg::AddrW-1:0]  gpu_address_o,
  output logic      [brsa_pkg::CntW-1:0]   granted_count_o
);
  import brsa_pkg::*;

  cfg_t      cfg;
  map_ctrl_t map_ctrl;
  logic      tap;

  brsa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  brsa_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (map_ctrl),
    .tap_o  (tap)
  );

  brsa_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .count_i         (count_i),
    .start_index_i   (start_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ok_o            (ok_o),
    .first_slot_o    (first_slot_o),
    .cpu_address_o   (cpu_address_o),
    .gpu_address_o   (gpu_address_o),
    .granted_count_o (granted_count_o),
    .cfg_i           (cfg),
    .tap_i           (tap),
    .map_ctrl_o      (map_ctrl)
  );

endmodule

`default_nettype wire

[hw/rtl/brsa_cfg.sv]
// APB-style register file for the slot allocator: base addresses, slot stride
// and active slot count. Depends on brsa_pkg.
`default_nettype none

module brsa_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [brsa_pkg::PaddrW-1:0] paddr,
  input  wire logic [brsa_pkg::DataW-1:0]  pwdata,
  output logic      [brsa_pkg::DataW-1:0]  prdata,
  output logic                             pready,
  output brsa_pkg::cfg_t                   cfg_o
);
  import brsa_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[PaddrW-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegCpuBase: cfg_d.cpu_base = pwdata[AddrW-1:0];
        RegGpuBase: cfg_d.gpu_base = pwdata[AddrW-1:0];
        RegStride:  cfg_d.stride   = pwdata[StrideW-1:0];
        RegActive:  cfg_d.active   = pwdata[CntW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegCpuBase: prdata = DataW'(cfg_q.cpu_base);
      RegGpuBase: prdata = DataW'(cfg_q.gpu_base);
      RegStride:  prdata = DataW'(cfg_q.stride);
      RegActive:  prdata = DataW'(cfg_q.active);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cpu_base <= '0;
      cfg_q.gpu_base <= '0;
      cfg_q.stride   <= StrideRst;
      cfg_q.active   <= ActiveRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/brsa_map.sv]
// Slot used map held as a rotating shift register: one slot passes the tap
// per shift, and a full pass of Slots shifts restores alignment. Depends on brsa_pkg.
`default_nettype none

module brsa_map (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire brsa_pkg::map_ctrl_t ctrl_i,
  output logic                     tap_o
);
  import brsa_pkg::*;

  logic [Slots-1:0] map_q, map_d;

  assign tap_o = map_q[0];

  always_comb begin
    map_d = map_q;
    if (ctrl_i.shift) begin
      map_d = {ctrl_i.wr_bit, map_q[Slots-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
    end else begin
      map_q <= map_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/brsa_seq.sv]
// Command sequencer: bit-serial first-fit scan, mark and clear passes over the
// rotating slot map, address build and output register. Depends on brsa_pkg.
`default_nettype none

module brsa_seq (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        command_i,
  input  wire logic [brsa_pkg::CntW-1:0]   count_i,
  input  wire logic [brsa_pkg::IdxW-1:0]   start_index_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             ok_o,
  output logic      [brsa_pkg::IdxW-1:0]   first_slot_o,
  output logic      [brsa_pkg::AddrW-1:0]  cpu_address_o,
  output logic      [brsa_pkg::AddrW-1:0]  gpu_address_o,
  output logic      [brsa_pkg::CntW-1:0]   granted_count_o,
  input  wire brsa_pkg::cfg_t              cfg_i,
  input  wire logic                        tap_i,
  output brsa_pkg::map_ctrl_t              map_ctrl_o
);
  import brsa_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StMark,
    StClear,
    StFinish
  } state_e;

  state_e            state_q, state_d;
  logic              cmd_q, cmd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]   base_q, base_d;
  logic [OffW-1:0]   boff_q, boff_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [OffW-1:0]   off_q, off_d;
  logic [CntW-1:0]   run_q, run_d;
  logic              hit_q, hit_d;
  logic              ovld_q, ovld_d;
  logic              ok_q, ok_d;
  logic [IdxW-1:0]   slot_q, slot_d;
  logic [AddrW-1:0]  cpu_q, cpu_d;
  logic [AddrW-1:0]  gpu_q, gpu_d;
  logic [CntW-1:0]   gcnt_q, gcnt_d;

  logic [CntW-1:0]   active_eff;
  logic [CntW-1:0]   idx_ext;
  logic [CntW-1:0]   rel;
  logic              in_act;
  logic              in_span;
  logic              last;
  logic              granted;

  assign active_eff = (cfg_i.active > SlotsCnt) ? SlotsCnt : cfg_i.active;
  assign idx_ext    = CntW'(idx_q);
  assign rel        = idx_ext - CntW'(base_q);
  assign in_act     = idx_ext < active_eff;
  assign in_span    = (idx_ext >= CntW'(base_q)) && (rel < cnt_q);
  assign last       = idx_q == LastIdx;
  assign granted    = (cmd_q == CmdAlloc) && hit_q;

  assign in_stall_o      = state_q != StIdle;
  assign out_valid_o     = ovld_q;
  assign ok_o            = ok_q;
  assign first_slot_o    = slot_q;
  assign cpu_address_o   = cpu_q;
  assign gpu_address_o   = gpu_q;
  assign granted_count_o = gcnt_q;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    cnt_d   = cnt_q;
    base_d  = base_q;
    boff_d  = boff_q;
    idx_d   = idx_q;
    off_d   = off_q;
    run_d   = run_q;
    hit_d   = hit_q;
    ovld_d  = ovld_q && out_stall_i;
    ok_d    = ok_q;
    slot_d  = slot_q;
    cpu_d   = cpu_q;
    gpu_d   = gpu_q;
    gcnt_d  = gcnt_q;
    map_ctrl_o.shift  = 1'b0;
    map_ctrl_o.wr_bit = tap_i;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_d   = command_i;
          cnt_d   = count_i;
          base_d  = start_index_i;
          boff_d  = '0;
          idx_d   = '0;
          off_d   = '0;
          run_d   = '0;
          hit_d   = 1'b0;
          state_d = (command_i == CmdFree) ? StClear : StScan;
        end
      end
      StScan: begin
        map_ctrl_o.shift = 1'b1;
        if (!hit_q && in_act) begin
          if (tap_i) begin
            run_d = '0;
          end else begin
            if (run_q == '0) begin
              base_d = idx_q;
              boff_d = off_q;
            end
            run_d = run_q + 1'b1;
            if (run_d == cnt_q) begin
              hit_d = 1'b1;
            end
          end
        end
        off_d = off_q + OffW'(cfg_i.stride);
        idx_d = last ? '0 : idx_q + 1'b1;
        if (last) begin
          off_d   = '0;
          state_d = hit_d ? StMark : StFinish;
        end
      end
      StMark: begin
        map_ctrl_o.shift  = 1'b1;
        map_ctrl_o.wr_bit = tap_i || in_span;
        idx_d = last ? '0 : idx_q + 1'b1;
        if (last) begin
          state_d = StFinish;
        end
      end
      StClear: begin
        map_ctrl_o.shift  = 1'b1;
        map_ctrl_o.wr_bit = tap_i && !(in_span && in_act);
        idx_d = last ? '0 : idx_q + 1'b1;
        if (last) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!ovld_q || !out_stall_i) begin
          ovld_d  = 1'b1;
          ok_d    = (cmd_q == CmdFree) || hit_q;
          slot_d  = granted ? base_q : '0;
          cpu_d   = granted ? cfg_i.cpu_base + AddrW'(boff_q) : '0;
          gpu_d   = granted ? cfg_i.gpu_base + AddrW'(boff_q) : '0;
          gcnt_d  = granted ? cnt_q : '0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cmd_q   <= 1'b0;
      cnt_q   <= '0;
      base_q  <= '0;
      boff_q  <= '0;
      idx_q   <= '0;
      off_q   <= '0;
      run_q   <= '0;
      hit_q   <= 1'b0;
      ovld_q  <= 1'b0;
      ok_q    <= 1'b0;
      slot_q  <= '0;
      cpu_q   <= '0;
      gpu_q   <= '0;
      gcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      cnt_q   <= cnt_d;
      base_q  <= base_d;
      boff_q  <= boff_d;
      idx_q   <= idx_d;
      off_q   <= off_d;
      run_q   <= run_d;
      hit_q   <= hit_d;
      ovld_q  <= ovld_d;
      ok_q    <= ok_d;
      slot_q  <= slot_d;
      cpu_q   <= cpu_d;
      gpu_q   <= gpu_d;
      gcnt_q  <= gcnt_d;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == StScan || state_q == StClear)
    else $error("accepted command did not start a pass");

  a_idle_counters_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> idx_q == '0 && off_q == '0)
    else $error("pass counters not cleared between commands");

  a_mark_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMark |-> hit_q)
    else $error("mark pass without a found run");

  a_fail_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> granted_count_o == '0 && first_slot_o == '0)
    else $error("failed allocate carries non-zero fields");

endmodule

`default_nettype wire

[bench/bitmap_range_slot_allocator_test.sv]
// Self-checking bench for bitmap_range_slot_allocator: directed and random
// allocate/free transfers checked against an in-bench first-fit slot map.
// Depends on brsa_pkg and the allocator RTL.
module bitmap_range_slot_allocator_test;
  import brsa_pkg::*;

  localparam int unsigned CycleLimit = 6_000_000;

  typedef struct packed {
    cmd_e             cmd;
    logic [CntW-1:0]  count;
    logic [IdxW-1:0]  start;
  } slot_cmd_t;

  typedef struct packed {
    logic             ok;
    logic [IdxW-1:0]  first;
    logic [AddrW-1:0] cpu;
    logic [AddrW-1:0] gpu;
    logic [CntW-1:0]  granted;
  } slot_grant_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              command_i = 1'b0;
  logic [CntW-1:0]   count_i = '0;
  logic [IdxW-1:0]   start_index_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              ok_o;
  logic [IdxW-1:0]   first_slot_o;
  logic [AddrW-1:0]  cpu_address_o;
  logic [AddrW-1:0]  gpu_address_o;
  logic [CntW-1:0]   granted_count_o;

  bitmap_range_slot_allocator i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .command_i, .count_i, .start_index_i,
    .out_valid_o, .out_stall_i, .ok_o, .first_slot_o, .cpu_address_o,
    .gpu_address_o, .granted_count_o
  );

  // shadow of the allocator
  logic [AddrW-1:0]   cpu_base_cfg = '0;
  logic [AddrW-1:0]   gpu_base_cfg = '0;
  logic [StrideW-1:0] stride_cfg = StrideRst;
  logic [CntW-1:0]    active_cfg = ActiveRst;
  bit [Slots-1:0]     used_map = '0;

  slot_cmd_t     cmd_backlog[$];
  slot_grant_t   grants_due[$];
  slot_cmd_t     in_flight;
  int unsigned   send_idle = 22;
  int unsigned   recv_idle = 63;
  int unsigned   errors = 0;
  int unsigned   cycle_count = 0;

  always #4 clk_i = ~clk_i;

  function automatic int unsigned active_limit();
    return (active_cfg > Slots) ? Slots : int'(active_cfg);
  endfunction

  function automatic slot_grant_t grant_or_release(slot_cmd_t c);
    slot_grant_t r;
    int unsigned lim;
    int unsigned run;
    int unsigned pos;
    int unsigned k;
    int unsigned first;
    r = '0;
    lim = active_limit();
    if (c.cmd == CmdFree) begin
      for (k = 0; k < c.count; k++) begin
        if (c.start + k < lim) used_map[c.start + k] = 1'b0;
      end
      r.ok = 1'b1;
      return r;
    end
    if (c.count == 0 || c.count > lim) return r;
    run = 0;
    for (pos = 0; pos < lim; pos++) begin
      run = used_map[pos] ? 0 : run + 1;
      if (run == c.count) begin
        first = pos + 1 - c.count;
        for (k = 0; k < c.count; k++) used_map[first + k] = 1'b1;
        r.ok = 1'b1;
        r.first = IdxW'(first);
        r.cpu = AddrW'(64'(cpu_base_cfg) + 64'(first) * 64'(stride_cfg));
        r.gpu = AddrW'(64'(gpu_base_cfg) + 64'(first) * 64'(stride_cfg));
        r.granted = c.count;
        break;
      end
    end
    return r;
  endfunction

  function automatic slot_cmd_t random_cmd();
    slot_cmd_t c;
    int unsigned roll;
    int unsigned lim;
    lim = active_limit();
    c.cmd = ($urandom_range(99) < 55) ? CmdAlloc : CmdFree;
    roll = $urandom_range(99);
    if (roll < 60) c.count = CntW'($urandom_range(8, 1));
    else if (roll < 85) c.count = CntW'($urandom_range(40, 9));
    else if (roll < 93) c.count = CntW'($urandom_range(256, 41));
    else if (roll < 97) c.count = '0;
    else c.count = CntW'($urandom_range(511, 257));
    if (lim == 0 || $urandom_range(1) == 0) c.start = IdxW'($urandom_range(255));
    else c.start = IdxW'($urandom_range(lim - 1));
    return c;
  endfunction

  task automatic push_cmd(input cmd_e c, input int unsigned cnt, input int unsigned st);
    cmd_backlog.push_back(slot_cmd_t'{c, CntW'(cnt), IdxW'(st)});
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PaddrW'({idx, 3'b000});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegCpuBase: cpu_base_cfg = value[AddrW-1:0];
      RegGpuBase: gpu_base_cfg = value[AddrW-1:0];
      RegStride:  stride_cfg = value[StrideW-1:0];
      RegActive:  active_cfg = value[CntW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (cmd_backlog.size() != 0 || in_valid_i || grants_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic run_batch(input logic [DataW-1:0] cpu_v, input logic [DataW-1:0] gpu_v,
                           input logic [DataW-1:0] stride_v, input logic [DataW-1:0] active_v,
                           input int unsigned n);
    write_reg(RegCpuBase, cpu_v);
    write_reg(RegGpuBase, gpu_v);
    write_reg(RegStride, stride_v);
    write_reg(RegActive, active_v);
    repeat (n) cmd_backlog.push_back(random_cmd());
    drain();
  endtask

  function automatic logic [DataW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("bitmap_range_slot_allocator_test failed");
      $finish;
    end
  end

  // driver: hold the payload while stalled, advance after each transfer
  always @(posedge clk_i) begin : feed_commands
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) grants_due.push_back(grant_or_release(in_flight));
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_flight = cmd_backlog.pop_front();
        command_i <= in_flight.cmd;
        count_i <= in_flight.count;
        start_index_i <= in_flight.start;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : watch_results
    slot_grant_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (grants_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual ok=%b first_slot=%0d",
                   $time, ok_o, first_slot_o);
          errors++;
        end else begin
          want = grants_due.pop_front();
          compare_field("ok", 64'(want.ok), 64'(ok_o));
          compare_field("first_slot", 64'(want.first), 64'(first_slot_o));
          compare_field("cpu_address", 64'(want.cpu), 64'(cpu_address_o));
          compare_field("gpu_address", 64'(want.gpu), 64'(gpu_address_o));
          compare_field("granted_count", 64'(want.granted), 64'(granted_count_o));
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_cmd(CmdAlloc, 0, 0);
    push_cmd(CmdAlloc, 256, 17);
    push_cmd(CmdAlloc, 1, 0);
    push_cmd(CmdFree, 256, 0);
    push_cmd(CmdAlloc, 1, 255);
    push_cmd(CmdAlloc, 3, 0);
    push_cmd(CmdAlloc, 2, 0);
    push_cmd(CmdFree, 3, 1);
    push_cmd(CmdAlloc, 4, 0);
    push_cmd(CmdAlloc, 3, 0);
    push_cmd(CmdFree, 0, 0);
    push_cmd(CmdAlloc, 257, 0);
    push_cmd(CmdFree, 511, 255);
    push_cmd(CmdAlloc, 511, 170);
    push_cmd(CmdFree, 256, 0);
    push_cmd(CmdAlloc, 255, 0);
    push_cmd(CmdAlloc, 1, 0);
    push_cmd(CmdAlloc, 1, 0);
    push_cmd(CmdFree, 1, 255);
    push_cmd(CmdFree, 1, 255);
    push_cmd(CmdAlloc, 1, 85);
    push_cmd(CmdFree, 256, 0);
    drain();

    run_batch(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'd8191, 64'd511, 200);
    run_batch(rand64(), rand64(), 64'd8191, 64'd256, 200);
    run_batch(rand64(), 64'h0000_FFFF_FFFF_FFFF, 64'd0, 64'd1, 60);

    send_idle = 63;
    recv_idle = 22;
    run_batch(rand64(), rand64(), 64'd1, 64'd0, 40);
    run_batch(rand64(), rand64(), 64'd4096, 64'd100, 400);

    send_idle = 0;
    recv_idle = 0;
    run_batch(rand64(), rand64(), 64'($urandom_range(4096, 1)), 64'd256, 450);
    run_batch(rand64(), rand64(), rand64(), 64'($urandom_range(255, 2)), 400);

    repeat (600) @(posedge clk_i);
    if (errors == 0) begin
      $display("bitmap_range_slot_allocator_test passed");
    end else begin
      $display("bitmap_range_slot_allocator_test failed");
    end
    $finish;
  end

endmodule
